### hw/rtl/cbc_pkg.sv
`default_nettype none
package cbc_pkg;

  localparam int ADDR_W       = 16;
  localparam int DATA_W       = 8;
  localparam int ROM_ADDR_W   = 21;
  localparam int KIND_W       = 2;
  localparam int ROM_CNT_W    = 8;
  localparam int RAM_CNT_W    = 3;
  localparam int BANK_W       = 7;
  localparam int KEY_W        = 4;
  localparam int SEL_W        = 4;
  localparam int CFG_IDX_W    = 1;
  localparam int RAM_WIN_BITS = 13;
  localparam int ROM_WIN_BITS = 14;
  localparam int CLK_REGS     = 5;
  localparam int CLK_IDX_W    = 3;

  localparam logic [ADDR_W-1:0]    CTRL_END      = 16'h8000;
  localparam logic [ADDR_W-1:0]    RAM_BASE      = 16'hA000;
  localparam logic [ADDR_W-1:0]    RAM_END       = 16'hC000;
  localparam logic [KEY_W-1:0]     ENABLE_KEY    = 4'hA;
  localparam logic [DATA_W-1:0]    OPEN_BUS      = 8'hFF;
  localparam logic [SEL_W-1:0]     CLK_SEL_BASE  = 4'h8;
  localparam logic [SEL_W-1:0]     CLK_SEL_LAST  = 4'hC;
  localparam logic [ROM_CNT_W-1:0] ROM_CNT_RESET = 8'd128;
  localparam logic [RAM_CNT_W-1:0] RAM_CNT_RESET = 3'd4;
  localparam logic [BANK_W-1:0]    BANK_RESET    = 7'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_HERE = 2'd0,
    KIND_ROM  = 2'd1,
    KIND_PASS = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROM_BANKS = 1'b0,
    CFG_RAM_BANKS = 1'b1
  } cfg_idx_t;

  // control register region below 0x8000, selected by address bits 14:13
  typedef enum logic [1:0] {
    REG_KEY   = 2'd0,
    REG_BANK  = 2'd1,
    REG_SEL   = 2'd2,
    REG_LATCH = 2'd3
  } reg_sel_t;

endpackage
`default_nettype wire

### hw/rtl/cbc_in_if.sv
`default_nettype none
interface cbc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [cbc_pkg::ADDR_W-1:0]  address;
  logic [cbc_pkg::DATA_W-1:0]  write_data;

  modport source (output valid, output func, output address, output write_data, input ready);
  modport sink   (input valid, input func, input address, input write_data, output ready);
endinterface
`default_nettype wire

### hw/rtl/cbc_out_if.sv
`default_nettype none
interface cbc_out_if;
  logic                            valid;
  logic                            ready;
  logic [cbc_pkg::KIND_W-1:0]      result_kind;
  logic [cbc_pkg::DATA_W-1:0]      read_data;
  logic [cbc_pkg::ROM_ADDR_W-1:0]  rom_address;

  modport source (output valid, output result_kind, output read_data, output rom_address,
                  input ready);
  modport sink   (input valid, input result_kind, input read_data, input rom_address,
                  output ready);
endinterface
`default_nettype wire

### hw/rtl/cbc_cfg_if.sv
`default_nettype none
interface cbc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cbc_pkg::CFG_IDX_W-1:0]  index;
  logic [cbc_pkg::DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/cbc_ram.sv
`default_nettype none
module cbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/cbc_bank_mod.sv
`default_nettype none
// restoring remainder, one dividend bit per cycle
module cbc_bank_mod (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [cbc_pkg::BANK_W-1:0]        dividend,
  input  wire logic [cbc_pkg::ROM_CNT_W-1:0]     divisor,
  output logic                                   busy,
  output logic      [cbc_pkg::BANK_W-1:0]        rem
);

  localparam int CNT_W = $clog2(cbc_pkg::BANK_W);

  logic [cbc_pkg::ROM_CNT_W-1:0] rem_r, rem_nxt;
  logic [cbc_pkg::BANK_W-1:0]    dvd_r, dvd_nxt;
  logic [cbc_pkg::ROM_CNT_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic [cbc_pkg::ROM_CNT_W-1:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[cbc_pkg::ROM_CNT_W-2:0], dvd_r[cbc_pkg::BANK_W-1]};
    if (start) begin
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(cbc_pkg::BANK_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = (trial >= dvs_r) ? trial - dvs_r : trial;
      dvd_nxt = {dvd_r[cbc_pkg::BANK_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rem_r  <= cbc_pkg::ROM_CNT_W'(cbc_pkg::BANK_RESET);
    end else begin
      busy_r <= busy_nxt;
      rem_r  <= rem_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign busy = busy_r;
  assign rem  = rem_r[cbc_pkg::BANK_W-1:0];

endmodule
`default_nettype wire

### hw/rtl/cartridge_bank_controller_rtc.sv
`default_nettype none
// Cartridge bank controller with clock register file. Takes one bus access per input beat
// and gives exactly one result beat: ROM fetch address, a byte handled here, or pass-on.
// After reset the external RAM is swept to zero, one byte per cycle, across all MAX_RAM_BANKS * 8192
// bytes; no access is taken during that sweep (configuration writes are). No new access is taken
// until the current one is finished, and a read of external RAM goes through a further state for
// the registered RAM read. A ROM bank write or a write of the ROM bank count starts the bank
// modulo unit, which works one bit per cycle and holds off the next access until it has finished.
// A stalled result sits in the output register while the block finishes the next access; a
// second finished result then waits inside until the first is taken.
module cartridge_bank_controller_rtc #(
  parameter int MAX_RAM_BANKS = 4,
  parameter int MAX_ROM_BANKS = 128
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cbc_in_if.sink      in_bus,
  cbc_out_if.source   out_bus,
  cbc_cfg_if.sink     cfg_bus
);

  localparam int RAM_DEPTH = MAX_RAM_BANKS * (1 << cbc_pkg::RAM_WIN_BITS);
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_READ, ST_DONE} state_t;

  state_t                           state_r, state_nxt;
  logic                             func_r, func_nxt;
  logic [cbc_pkg::ADDR_W-1:0]       addr_r, addr_nxt;
  logic [cbc_pkg::DATA_W-1:0]       wdata_r, wdata_nxt;

  logic [cbc_pkg::ROM_CNT_W-1:0]    rom_cnt_r, rom_cnt_nxt;
  logic [cbc_pkg::RAM_CNT_W-1:0]    ram_cnt_r, ram_cnt_nxt;
  logic [cbc_pkg::KEY_W-1:0]        key_r, key_nxt;
  logic [cbc_pkg::BANK_W-1:0]       bank_r, bank_nxt;
  logic [cbc_pkg::SEL_W-1:0]        sel_r, sel_nxt;
  logic [cbc_pkg::DATA_W-1:0]       clk_r   [cbc_pkg::CLK_REGS];
  logic [cbc_pkg::DATA_W-1:0]       clk_nxt [cbc_pkg::CLK_REGS];

  logic                             mod_req_r, mod_req_nxt;
  logic                             clr_busy_r, clr_busy_nxt;
  logic [RAM_AW-1:0]                clr_addr_r, clr_addr_nxt;

  logic                             out_valid_r, out_valid_nxt;
  cbc_pkg::kind_t                   out_kind_r, out_kind_nxt;
  logic [cbc_pkg::DATA_W-1:0]       out_rdata_r, out_rdata_nxt;
  logic [cbc_pkg::ROM_ADDR_W-1:0]   out_raddr_r, out_raddr_nxt;
  cbc_pkg::kind_t                   res_kind_r, res_kind_nxt;
  logic [cbc_pkg::DATA_W-1:0]       res_rdata_r, res_rdata_nxt;
  logic [cbc_pkg::ROM_ADDR_W-1:0]   res_raddr_r, res_raddr_nxt;

  logic                             fin;
  cbc_pkg::kind_t                   fin_kind;
  logic [cbc_pkg::DATA_W-1:0]       fin_rdata;
  logic [cbc_pkg::ROM_ADDR_W-1:0]   fin_raddr;

  logic                             in_fire, cfg_fire, out_fire, slot_free;
  logic [cbc_pkg::ROM_CNT_W-1:0]    eff_rom;
  logic [3:0]                       eff_ram;
  logic [2:0]                       ram_bank;
  logic [RAM_AW-1:0]                ram_idx;
  logic                             ram_we;
  logic [RAM_AW-1:0]                ram_waddr;
  logic [cbc_pkg::DATA_W-1:0]       ram_wdata;
  logic [cbc_pkg::DATA_W-1:0]       ram_rdata;
  logic                             mod_start, mod_busy;
  logic [cbc_pkg::BANK_W-1:0]       mod_rem;
  logic                             win_on, in_ram_win, ram_sel, clk_sel;
  logic [cbc_pkg::CLK_IDX_W-1:0]    clk_idx;

  // small remainder of a 3-bit select by the effective RAM bank count of 0..MAX_RAM_BANKS
  function automatic logic [2:0] sel_mod(input logic [2:0] s, input logic [3:0] d);
    logic [3:0] r;
    r = '0;
    for (int i = 2; i >= 0; i--) begin
      r = {r[2:0], s[i]};
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[2:0];
  endfunction

  assign in_fire   = in_bus.valid && in_bus.ready;
  assign cfg_fire  = cfg_bus.valid && cfg_bus.ready;
  assign out_fire  = out_valid_r && out_bus.ready;
  assign slot_free = !out_valid_r || out_bus.ready;

  assign in_bus.ready  = (state_r == ST_IDLE) && !clr_busy_r && !mod_req_r && !mod_busy;
  assign cfg_bus.ready = 1'b1;

  assign out_bus.valid       = out_valid_r;
  assign out_bus.result_kind = out_kind_r;
  assign out_bus.read_data   = out_rdata_r;
  assign out_bus.rom_address = out_raddr_r;

  always_comb begin
    eff_rom = rom_cnt_r;
    if (rom_cnt_r == '0) begin
      eff_rom = cbc_pkg::ROM_CNT_W'(1);
    end else if (rom_cnt_r > cbc_pkg::ROM_CNT_W'(MAX_ROM_BANKS)) begin
      eff_rom = cbc_pkg::ROM_CNT_W'(MAX_ROM_BANKS);
    end
    eff_ram = ({1'b0, ram_cnt_r} > 4'(MAX_RAM_BANKS)) ? 4'(MAX_RAM_BANKS) : {1'b0, ram_cnt_r};
  end

  assign ram_bank   = sel_mod(sel_r[2:0], eff_ram);
  assign ram_idx    = (RAM_AW'(ram_bank) << cbc_pkg::RAM_WIN_BITS)
                    | RAM_AW'(addr_r[cbc_pkg::RAM_WIN_BITS-1:0]);
  assign win_on     = (key_r == cbc_pkg::ENABLE_KEY);
  assign in_ram_win = (addr_r >= cbc_pkg::RAM_BASE) && (addr_r < cbc_pkg::RAM_END);
  assign ram_sel    = (sel_r < cbc_pkg::CLK_SEL_BASE) && (eff_ram != '0);
  assign clk_sel    = (sel_r >= cbc_pkg::CLK_SEL_BASE) && (sel_r <= cbc_pkg::CLK_SEL_LAST);
  assign clk_idx    = cbc_pkg::CLK_IDX_W'(sel_r - cbc_pkg::CLK_SEL_BASE);
  assign mod_start  = mod_req_r && !mod_busy;

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    addr_nxt      = addr_r;
    wdata_nxt     = wdata_r;
    rom_cnt_nxt   = rom_cnt_r;
    ram_cnt_nxt   = ram_cnt_r;
    key_nxt       = key_r;
    bank_nxt      = bank_r;
    sel_nxt       = sel_r;
    clk_nxt       = clk_r;
    mod_req_nxt   = mod_req_r;
    clr_busy_nxt  = clr_busy_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_rdata_nxt = out_rdata_r;
    out_raddr_nxt = out_raddr_r;
    res_kind_nxt  = res_kind_r;
    res_rdata_nxt = res_rdata_r;
    res_raddr_nxt = res_raddr_r;
    fin           = 1'b0;
    fin_kind      = cbc_pkg::KIND_HERE;
    fin_rdata     = '0;
    fin_raddr     = '0;
    ram_we        = 1'b0;
    ram_waddr     = ram_idx;
    ram_wdata     = wdata_r;

    if (mod_start) begin
      mod_req_nxt = 1'b0;
    end

    // zero sweep of external RAM after reset
    if (clr_busy_r) begin
      ram_we       = 1'b1;
      ram_waddr    = clr_addr_r;
      ram_wdata    = '0;
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == RAM_AW'(RAM_DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end

    if (cfg_fire) begin
      case (cbc_pkg::cfg_idx_t'(cfg_bus.index))
        cbc_pkg::CFG_ROM_BANKS: begin
          rom_cnt_nxt = cfg_bus.data;
          mod_req_nxt = 1'b1;
        end
        cbc_pkg::CFG_RAM_BANKS: ram_cnt_nxt = cfg_bus.data[cbc_pkg::RAM_CNT_W-1:0];
        default: ;
      endcase
    end

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          func_nxt  = in_bus.func;
          addr_nxt  = in_bus.address;
          wdata_nxt = in_bus.write_data;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        fin = 1'b1;
        if (addr_r < cbc_pkg::CTRL_END) begin
          if (func_r) begin
            case (cbc_pkg::reg_sel_t'(addr_r[14:13]))
              cbc_pkg::REG_KEY: key_nxt = wdata_r[cbc_pkg::KEY_W-1:0];
              cbc_pkg::REG_BANK: begin
                bank_nxt    = (wdata_r[cbc_pkg::BANK_W-1:0] == '0) ? cbc_pkg::BANK_RESET
                                                                    : wdata_r[cbc_pkg::BANK_W-1:0];
                mod_req_nxt = 1'b1;
              end
              cbc_pkg::REG_SEL: sel_nxt = wdata_r[cbc_pkg::SEL_W-1:0];
              // latch writes have no effect without clock ticking
              cbc_pkg::REG_LATCH: ;
              default: ;
            endcase
          end else begin
            fin_kind  = cbc_pkg::KIND_ROM;
            fin_raddr = addr_r[cbc_pkg::ROM_WIN_BITS]
                      ? cbc_pkg::ROM_ADDR_W'({mod_rem, addr_r[cbc_pkg::ROM_WIN_BITS-1:0]})
                      : cbc_pkg::ROM_ADDR_W'(addr_r[cbc_pkg::ROM_WIN_BITS-1:0]);
          end
        end else if (in_ram_win) begin
          if (func_r) begin
            if (win_on && ram_sel) begin
              ram_we = 1'b1;
            end else if (win_on && clk_sel) begin
              clk_nxt[clk_idx] = wdata_r;
            end
          end else begin
            fin_rdata = cbc_pkg::OPEN_BUS;
            if (win_on && ram_sel) begin
              // ram read issued this cycle, data next cycle
              fin       = 1'b0;
              state_nxt = ST_READ;
            end else if (win_on && clk_sel) begin
              fin_rdata = clk_r[clk_idx];
            end
          end
        end else begin
          fin_kind = cbc_pkg::KIND_PASS;
        end
      end
      ST_READ: begin
        fin       = 1'b1;
        fin_rdata = ram_rdata;
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_rdata_nxt = res_rdata_r;
          out_raddr_nxt = res_raddr_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (fin) begin
      if (slot_free) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = fin_kind;
        out_rdata_nxt = fin_rdata;
        out_raddr_nxt = fin_raddr;
        state_nxt     = ST_IDLE;
      end else begin
        res_kind_nxt  = fin_kind;
        res_rdata_nxt = fin_rdata;
        res_raddr_nxt = fin_raddr;
        state_nxt     = ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rom_cnt_r   <= cbc_pkg::ROM_CNT_RESET;
      ram_cnt_r   <= cbc_pkg::RAM_CNT_RESET;
      key_r       <= '0;
      bank_r      <= cbc_pkg::BANK_RESET;
      sel_r       <= '0;
      for (int i = 0; i < cbc_pkg::CLK_REGS; i++) begin
        clk_r[i] <= '0;
      end
      mod_req_r   <= 1'b0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rom_cnt_r   <= rom_cnt_nxt;
      ram_cnt_r   <= ram_cnt_nxt;
      key_r       <= key_nxt;
      bank_r      <= bank_nxt;
      sel_r       <= sel_nxt;
      clk_r       <= clk_nxt;
      mod_req_r   <= mod_req_nxt;
      clr_busy_r  <= clr_busy_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r      <= func_nxt;
    addr_r      <= addr_nxt;
    wdata_r     <= wdata_nxt;
    out_kind_r  <= out_kind_nxt;
    out_rdata_r <= out_rdata_nxt;
    out_raddr_r <= out_raddr_nxt;
    res_kind_r  <= res_kind_nxt;
    res_rdata_r <= res_rdata_nxt;
    res_raddr_r <= res_raddr_nxt;
  end

  cbc_ram #(
    .WIDTH (cbc_pkg::DATA_W),
    .DEPTH (RAM_DEPTH),
    .AW    (RAM_AW)
  ) u_ext_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_idx),
    .rdata (ram_rdata)
  );

  cbc_bank_mod u_bank_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (bank_r),
    .divisor  (eff_rom),
    .busy     (mod_busy),
    .rem      (mod_rem)
  );

  a_bank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    bank_r != '0)
    else $error("rom bank register holds zero");

  a_mod_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!mod_req_r && !mod_busy) |-> ({1'b0, mod_rem} < eff_rom))
    else $error("settled rom bank remainder not below bank count");

  a_rdata_only_here: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r != cbc_pkg::KIND_HERE)) |-> (out_rdata_r == '0))
    else $error("read data set on a rom or pass-on result");

  a_no_exec_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (state_r == ST_IDLE))
    else $error("access in progress during ram sweep");

endmodule
`default_nettype wire

### bench/cartridge_bank_controller_rtc_tb.sv
`timescale 1ns / 100ps

module cartridge_bank_controller_rtc_tb;

  localparam int RAM_BANKS_MAX  = 4;
  localparam int ROM_BANKS_MAX  = 128;
  localparam int RAM_BANK_BYTES = 8192;
  localparam int ROM_BANK_BYTES = 16384;
  localparam int RAM_BYTES      = RAM_BANKS_MAX * RAM_BANK_BYTES;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 20;
  localparam int CYCLE_LIMIT    = 600000;

  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  typedef struct packed {
    cbc_pkg::kind_t                  kind;
    logic [cbc_pkg::DATA_W-1:0]      rdata;
    logic [cbc_pkg::ROM_ADDR_W-1:0]  raddr;
  } bus_result_t;

  // tracks the controller registers, clock bytes and external ram
  class cart_tracker;
    logic [cbc_pkg::ROM_CNT_W-1:0] rom_banks_reg;
    logic [cbc_pkg::RAM_CNT_W-1:0] ram_banks_reg;
    logic [cbc_pkg::KEY_W-1:0]     enable_key;
    logic [cbc_pkg::BANK_W-1:0]    rom_bank;
    logic [cbc_pkg::SEL_W-1:0]     select;
    logic [cbc_pkg::DATA_W-1:0]    latch;
    logic [cbc_pkg::DATA_W-1:0]    rtc_bytes [cbc_pkg::CLK_REGS];
    logic [cbc_pkg::DATA_W-1:0]    xram [RAM_BYTES];
    bus_result_t                   due_results [$];
    int                            mismatches;
    int                            checked;
    int                            accesses;

    function new();
      rom_banks_reg = cbc_pkg::ROM_CNT_RESET;
      ram_banks_reg = cbc_pkg::RAM_CNT_RESET;
      enable_key    = '0;
      rom_bank      = cbc_pkg::BANK_RESET;
      select        = '0;
      latch         = '0;
      foreach (rtc_bytes[i]) rtc_bytes[i] = '0;
      foreach (xram[i]) xram[i] = '0;
      mismatches = 0;
      checked    = 0;
      accesses   = 0;
    endfunction

    function int rom_modulus();
      int n;
      n = int'(rom_banks_reg);
      if (n == 0) n = 1;
      if (n > ROM_BANKS_MAX) n = ROM_BANKS_MAX;
      return n;
    endfunction

    function int ram_modulus();
      int n;
      n = int'(ram_banks_reg);
      if (n > RAM_BANKS_MAX) n = RAM_BANKS_MAX;
      return n;
    endfunction

    function void set_reg(cbc_pkg::cfg_idx_t idx, logic [cbc_pkg::DATA_W-1:0] value);
      if (idx == cbc_pkg::CFG_ROM_BANKS) rom_banks_reg = value;
      else ram_banks_reg = value[cbc_pkg::RAM_CNT_W-1:0];
    endfunction

    function void note_access(logic func, logic [cbc_pkg::ADDR_W-1:0] addr,
                              logic [cbc_pkg::DATA_W-1:0] data);
      bus_result_t r;
      int          banks;
      int          idx;
      bit          is_wr;
      r.kind  = cbc_pkg::KIND_HERE;
      r.rdata = '0;
      r.raddr = '0;
      is_wr   = (func == ACC_WRITE);
      accesses++;
      if (addr < cbc_pkg::CTRL_END) begin
        if (is_wr) begin
          case (cbc_pkg::reg_sel_t'(addr[14:13]))
            cbc_pkg::REG_KEY:  enable_key = data[cbc_pkg::KEY_W-1:0];
            cbc_pkg::REG_BANK: rom_bank = (data[cbc_pkg::BANK_W-1:0] == '0)
                                        ? cbc_pkg::BANK_RESET : data[cbc_pkg::BANK_W-1:0];
            cbc_pkg::REG_SEL:  select = data[cbc_pkg::SEL_W-1:0];
            default:           latch = data;
          endcase
        end else begin
          r.kind = cbc_pkg::KIND_ROM;
          if (!addr[14]) begin
            r.raddr = cbc_pkg::ROM_ADDR_W'(addr);
          end else begin
            idx     = (int'(rom_bank) % rom_modulus()) * ROM_BANK_BYTES + int'(addr[13:0]);
            r.raddr = cbc_pkg::ROM_ADDR_W'(idx);
          end
        end
      end else if (addr >= cbc_pkg::RAM_BASE && addr < cbc_pkg::RAM_END) begin
        if (!is_wr) r.rdata = cbc_pkg::OPEN_BUS;
        if (enable_key == cbc_pkg::ENABLE_KEY) begin
          if (select < cbc_pkg::CLK_SEL_BASE) begin
            banks = ram_modulus();
            if (banks != 0) begin
              idx = (int'(select) % banks) * RAM_BANK_BYTES + int'(addr[12:0]);
              if (is_wr) xram[idx] = data;
              else r.rdata = xram[idx];
            end
          end else if (select <= cbc_pkg::CLK_SEL_LAST) begin
            idx = int'(select - cbc_pkg::CLK_SEL_BASE);
            if (is_wr) rtc_bytes[idx] = data;
            else r.rdata = rtc_bytes[idx];
          end
        end
      end else begin
        r.kind = cbc_pkg::KIND_PASS;
      end
      due_results.push_back(r);
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    endfunction

    function void check_result(logic [cbc_pkg::KIND_W-1:0] kind,
                               logic [cbc_pkg::DATA_W-1:0] rdata,
                               logic [cbc_pkg::ROM_ADDR_W-1:0] raddr);
      bus_result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with no access outstanding: kind %0h data %0h addr %0h",
                 $time, kind, rdata, raddr);
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (kind !== want.kind) flag("result_kind", 32'(want.kind), 32'(kind));
      if (rdata !== want.rdata) flag("read_data", 32'(want.rdata), 32'(rdata));
      if (raddr !== want.raddr) flag("rom_address", 32'(want.raddr), 32'(raddr));
    endfunction

    function int results_pending();
      return due_results.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  cbc_in_if  in_bus ();
  cbc_out_if out_bus ();
  cbc_cfg_if cfg_bus ();

  cartridge_bank_controller_rtc #(
    .MAX_RAM_BANKS(RAM_BANKS_MAX),
    .MAX_ROM_BANKS(ROM_BANKS_MAX)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  cart_tracker sb;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          settings_used = 0;
  int          holds_done = 0;
  bit          steady_sender = 0;
  bit          hold_off_req = 0;
  bit          hold_active = 0;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.results_pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      sb.check_result(out_bus.result_kind, out_bus.read_data, out_bus.rom_address);
  end

  // result side stall pattern, with an occasional long hold-off on request
  initial begin : result_sink
    int mode;
    int span;
    out_bus.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 0;
        hold_active  = 1;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 0;
        holds_done++;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(4, 60);
      repeat (span) begin
        case (mode)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= 1'($urandom_range(0, 1));
          2:       out_bus.ready <= ($urandom_range(0, 3) == 0);
          default: out_bus.ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send_access(input logic func, input logic [cbc_pkg::ADDR_W-1:0] addr,
                             input logic [cbc_pkg::DATA_W-1:0] data);
    int gap;
    if (!steady_sender) begin
      if (burst_left == 0) begin
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        burst_left = $urandom_range(1, 20);
        if (gap > 0) begin
          in_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_bus.valid      <= 1'b1;
    in_bus.func       <= func;
    in_bus.address    <= addr;
    in_bus.write_data <= data;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_access(func, addr, data);
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (sb.results_pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cbc_pkg::cfg_idx_t idx,
                           input logic [cbc_pkg::DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.set_reg(idx, value);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic pick_access(output logic func, output logic [cbc_pkg::ADDR_W-1:0] addr,
                             output logic [cbc_pkg::DATA_W-1:0] data);
    int pick;
    pick = $urandom_range(0, 99);
    func = ACC_WRITE;
    data = 8'($urandom_range(0, 255));
    if (pick < 8) begin
      addr = 16'($urandom_range(16'h0000, 16'h1FFF));
      if ($urandom_range(0, 3) != 0) data[3:0] = cbc_pkg::ENABLE_KEY;
    end else if (pick < 16) begin
      addr = 16'($urandom_range(16'h2000, 16'h3FFF));
    end else if (pick < 26) begin
      addr = 16'($urandom_range(16'h4000, 16'h5FFF));
      // mostly ram banks, the rest clock bytes and unused selects
      if ($urandom_range(0, 4) < 3) data[3] = 1'b0;
      else data[3] = 1'b1;
    end else if (pick < 29) begin
      addr = 16'($urandom_range(16'h6000, 16'h7FFF));
    end else if (pick < 42) begin
      func = ACC_READ;
      addr = 16'($urandom_range(16'h0000, 16'h7FFF));
    end else if (pick < 80) begin
      func = 1'($urandom_range(0, 1));
      // a small pool of offsets so reads land on bytes written earlier
      if ($urandom_range(0, 2) != 0) addr = cbc_pkg::RAM_BASE + 16'($urandom_range(0, 31));
      else addr = cbc_pkg::RAM_BASE + 16'($urandom_range(0, RAM_BANK_BYTES - 1));
    end else if (pick < 90) begin
      func = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 1) != 0) addr = 16'($urandom_range(16'h8000, 16'h9FFF));
      else addr = 16'($urandom_range(16'hC000, 16'hFFFF));
    end else begin
      func = 1'($urandom_range(0, 1));
      addr = 16'($urandom_range(0, 16'hFFFF));
    end
  endtask

  task automatic random_accesses(input int count);
    logic                       func;
    logic [cbc_pkg::ADDR_W-1:0] addr;
    logic [cbc_pkg::DATA_W-1:0] data;
    for (int i = 0; i < count; i++) begin
      // pause the sender once per phase until everything is back
      if (i == count / 2) begin
        steady_sender = 0;
        drain_results();
      end
      pick_access(func, addr, data);
      send_access(func, addr, data);
    end
  endtask

  task automatic run_phase(input logic [cbc_pkg::DATA_W-1:0] rom_cnt,
                           input logic [cbc_pkg::DATA_W-1:0] ram_cnt,
                           input int count, input bit squeeze);
    drain_results();
    write_reg(cbc_pkg::CFG_ROM_BANKS, rom_cnt);
    write_reg(cbc_pkg::CFG_RAM_BANKS, ram_cnt);
    settings_used++;
    if (squeeze) begin
      hold_off_req = 1;
      while (!hold_active) @(posedge clk);
      steady_sender = 1;
    end
    random_accesses(count);
  endtask

  task automatic directed_accesses();
    send_access(ACC_READ,  16'h0000, 8'h00);
    send_access(ACC_READ,  16'h3FFF, 8'hFF);
    send_access(ACC_READ,  16'h4000, 8'h00);
    send_access(ACC_READ,  16'h7FFF, 8'h00);
    // window still locked
    send_access(ACC_READ,  16'hA000, 8'h00);
    send_access(ACC_WRITE, 16'hBFFF, 8'h5A);
    send_access(ACC_WRITE, 16'h0000, 8'hFA);
    send_access(ACC_READ,  16'hBFFF, 8'h00);
    send_access(ACC_WRITE, 16'hA000, 8'hFF);
    send_access(ACC_READ,  16'hA000, 8'h00);
    // bank zero maps to one, then the top bank
    send_access(ACC_WRITE, 16'h2000, 8'h00);
    send_access(ACC_READ,  16'h4000, 8'h00);
    send_access(ACC_WRITE, 16'h3FFF, 8'hFF);
    send_access(ACC_READ,  16'h7FFF, 8'h00);
    send_access(ACC_WRITE, 16'h2000, 8'h80);
    send_access(ACC_WRITE, 16'h4000, 8'hF8);
    send_access(ACC_WRITE, 16'hA123, 8'h3C);
    send_access(ACC_READ,  16'hA123, 8'h00);
    send_access(ACC_WRITE, 16'h5FFF, 8'h0C);
    send_access(ACC_WRITE, 16'hB000, 8'hC3);
    send_access(ACC_READ,  16'hB000, 8'h00);
    send_access(ACC_WRITE, 16'h4000, 8'h0F);
    send_access(ACC_READ,  16'hA000, 8'h00);
    send_access(ACC_WRITE, 16'h6000, 8'hFF);
    send_access(ACC_WRITE, 16'h1FFF, 8'h0B);
    send_access(ACC_READ,  16'hFFFF, 8'h00);
    send_access(ACC_WRITE, 16'h8000, 8'h77);
  endtask

  initial begin : stimulus
    logic [cbc_pkg::DATA_W-1:0] rom_pick;
    logic [cbc_pkg::DATA_W-1:0] ram_pick;
    sb = new();
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.func       = ACC_READ;
    in_bus.address    = '0;
    in_bus.write_data = '0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = cbc_pkg::CFG_ROM_BANKS;
    cfg_bus.data      = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    settings_used = 1;
    directed_accesses();
    random_accesses(110);
    run_phase(8'd0,   8'd0,   110, 1'b0);
    run_phase(8'd255, 8'hFF,  110, 1'b0);
    run_phase(8'd1,   8'h01,  100, 1'b1);
    run_phase(8'd3,   8'hFA,  100, 1'b0);
    rom_pick = 8'($urandom_range(2, 127));
    ram_pick = {5'($urandom_range(0, 31)), 3'($urandom_range(0, 4))};
    run_phase(rom_pick, ram_pick, 100, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 90, 1'b0);
    run_phase(8'd128, 8'd4, 110, 1'b0);
    drain_results();

    $display("covered %0d bus accesses under %0d bank count settings, %0d results checked",
             sb.accesses, settings_used, sb.checked);
    $display("long result hold-offs: %0d, mismatches: %0d", holds_done, sb.mismatches);
    if (sb.mismatches == 0 && sb.results_pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/cbc_pkg.sv
hw/rtl/cbc_in_if.sv
hw/rtl/cbc_out_if.sv
hw/rtl/cbc_cfg_if.sv
hw/rtl/cbc_ram.sv
hw/rtl/cbc_bank_mod.sv
hw/rtl/cartridge_bank_controller_rtc.sv
bench/cartridge_bank_controller_rtc_tb.sv
